### src/eflt_pkg.sv
// shared widths, codes and entry type for the exclusive file lock table
package eflt_pkg;

  localparam int DEFAULT_LOCK_SLOTS = 8;

  localparam int OP_W     = 3;
  localparam int INODE_W  = 32;
  localparam int FS_W     = 32;
  localparam int DESC_W   = 9;
  localparam int UID_W    = 16;
  localparam int STATUS_W = 3;

  // input tdata: inode, fs_endpoint, descriptor, caller_uid, file_owner_uid,
  // opened_by_other_user, padded to whole bytes
  localparam int IN_FIELDS_W = INODE_W + FS_W + DESC_W + 2 * UID_W + 1;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((STATUS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_CHECK        = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE      = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK         = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCK_NOOTHER = 3'd3;
  localparam logic [OP_W-1:0] OP_UNLOCK       = 3'd4;
  localparam logic [OP_W-1:0] OP_FORCE_UNLOCK = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCESS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AGAIN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOPERM  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd6;

  typedef struct packed {
    logic [UID_W-1:0]   uid;
    logic [DESC_W-1:0]  desc;
    logic [FS_W-1:0]    fs;
    logic [INODE_W-1:0] inode;
  } entry_t;

endpackage

### src/exclusive_file_lock_table.sv
// exclusive file lock table: slot memory scanned once per request
// each accepted request sweeps every slot (scan), waits out the last read (drain),
//   then decides and registers its status once the output is free; one request at
//   a time, set by the single read port of the slot memory, swept one slot per cycle
// reset: rst_n (synchronous, active low) frees every slot at once through per-slot
//   valid flops and sets superuser_uid to 0; requests are taken the cycle after
module exclusive_file_lock_table #(
  parameter int LOCK_SLOTS = eflt_pkg::DEFAULT_LOCK_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [eflt_pkg::UID_W-1:0]      cfg_wr_data,   // superuser_uid
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // inode[31:0], fs_endpoint[63:32], descriptor[72:64], requester_uid[88:73],
  // file_owner_uid[104:89], opened_by_other_user[105], zero pad
  input  logic [eflt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [eflt_pkg::OP_W-1:0]       in_tuser,      // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [eflt_pkg::OUT_DATA_W-1:0] out_tdata      // status[2:0], zero pad
);
  import eflt_pkg::*;

  localparam int IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;

  logic [2:0] state_r, state_nxt;

  entry_t mem [LOCK_SLOTS];
  entry_t mem_q;
  logic   mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t mem_wdata;

  logic [LOCK_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [UID_W-1:0] super_uid_r;

  // request registers
  logic [OP_W-1:0]    req_op_r;
  logic [INODE_W-1:0] req_inode_r;
  logic [FS_W-1:0]    req_fs_r;
  logic [DESC_W-1:0]  req_desc_r;
  logic [UID_W-1:0]   req_caller_r;
  logic [UID_W-1:0]   req_owner_r;
  logic               req_others_r;

  // scan pipeline
  logic [IDX_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_en;

  // scan results
  logic             found_r, rel_found_r, free_found_r;
  logic [IDX_W-1:0] found_idx_r, rel_idx_r, free_idx_r;
  logic [UID_W-1:0] found_uid_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic in_acc, out_free, key_hit, rel_hit, cur_valid;
  logic [STATUS_W-1:0] status;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_status_r);
  assign out_free   = !out_valid_r || out_tready;

  assign rd_en     = (state_r == S_SCAN);
  assign cur_valid = slot_valid_r[rd_idx_r];
  assign key_hit   = rd_pend_r && cur_valid && (mem_q.inode == req_inode_r) &&
                     (mem_q.fs == req_fs_r);
  assign rel_hit   = key_hit && (mem_q.desc == req_desc_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr_r];
    end
  end

  // decision on the completed scan
  always_comb begin
    status         = ST_INVALID;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    mem_wdata      = '{uid: req_caller_r, desc: req_desc_r, fs: req_fs_r,
                       inode: req_inode_r};
    slot_valid_nxt = slot_valid_r;
    case (req_op_r)
      OP_CHECK: begin
        status = (found_r && (found_uid_r != req_caller_r)) ? ST_ACCESS : ST_OK;
      end
      OP_RELEASE: begin
        status = ST_OK;
        if (rel_found_r) begin
          slot_valid_nxt[rel_idx_r] = 1'b0;
        end
      end
      OP_LOCK, OP_LOCK_NOOTHER: begin
        if ((req_op_r == OP_LOCK_NOOTHER) && req_others_r) begin
          status = ST_AGAIN;
        end else if (req_inode_r == '0) begin
          status = ST_INVALID;
        end else if (found_r) begin
          status = ST_ALREADY;
        end else if (free_found_r) begin
          status = ST_OK;
          mem_we = 1'b1;
          slot_valid_nxt[free_idx_r] = 1'b1;
        end else begin
          status = ST_NOSLOT;
        end
      end
      OP_UNLOCK, OP_FORCE_UNLOCK: begin
        if (!found_r) begin
          status = ST_INVALID;
        end else if ((found_uid_r == req_caller_r) ||
                     ((req_op_r == OP_FORCE_UNLOCK) &&
                      ((super_uid_r == req_caller_r) ||
                       (req_owner_r == req_caller_r)))) begin
          status = ST_OK;
          slot_valid_nxt[found_idx_r] = 1'b0;
        end else begin
          status = ST_NOPERM;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
    // nothing commits outside the decide state or while the output register is still held
    if ((state_r != S_DECIDE) || !out_free) begin
      mem_we         = 1'b0;
      slot_valid_nxt = slot_valid_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rd_addr_nxt    = rd_addr_r;
    rd_pend_nxt    = rd_en;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt   = S_SCAN;
          rd_addr_nxt = '0;
        end
      end
      S_SCAN: begin
        if (rd_addr_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      super_uid_r  <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_addr_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_addr_r    <= rd_addr_nxt;
      if (cfg_wr_en) begin
        super_uid_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    rd_idx_r     <= rd_addr_r;
    if (in_acc) begin
      req_op_r     <= in_tuser;
      req_inode_r  <= in_tdata[INODE_W-1:0];
      req_fs_r     <= in_tdata[INODE_W +: FS_W];
      req_desc_r   <= in_tdata[INODE_W+FS_W +: DESC_W];
      req_caller_r <= in_tdata[INODE_W+FS_W+DESC_W +: UID_W];
      req_owner_r  <= in_tdata[INODE_W+FS_W+DESC_W+UID_W +: UID_W];
      req_others_r <= in_tdata[INODE_W+FS_W+DESC_W+2*UID_W];
      found_r      <= 1'b0;
      rel_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_pend_r) begin
      // keep the lowest matching and lowest free slot
      if (key_hit && !found_r) begin
        found_r     <= 1'b1;
        found_idx_r <= rd_idx_r;
        found_uid_r <= mem_q.uid;
      end
      if (rel_hit && !rel_found_r) begin
        rel_found_r <= 1'b1;
        rel_idx_r   <= rd_idx_r;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN))
    else $error("request accepted without starting a scan");

  a_write_only_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_DECIDE) && out_free && !slot_valid_r[free_idx_r]))
    else $error("slot memory written outside a lock commit or over a held slot");

  a_lock_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> ($countones(slot_valid_r) == $past($countones(slot_valid_r)) + 1))
    else $error("lock commit did not take exactly one slot");

  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DECIDE))
    else $error("status produced without a finished scan");

  a_no_read_while_writing: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && mem_we))
    else $error("slot memory read and written in the same cycle");

endmodule

### tb/lock_table_checker.sv
// predicts the lock table status for every request and compares it with each result
module lock_table_checker
  import eflt_pkg::*;
#(
  parameter int LOCK_SLOTS = DEFAULT_LOCK_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [UID_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    results_seen
);

  localparam int FS_LSB     = INODE_W;
  localparam int DESC_LSB   = FS_LSB + FS_W;
  localparam int CALLER_LSB = DESC_LSB + DESC_W;
  localparam int OWNER_LSB  = CALLER_LSB + UID_W;
  localparam int OTHERS_BIT = OWNER_LSB + UID_W;

  logic [INODE_W-1:0] held_inode [LOCK_SLOTS];
  logic [FS_W-1:0]    held_fs    [LOCK_SLOTS];
  logic [DESC_W-1:0]  held_desc  [LOCK_SLOTS];
  logic [UID_W-1:0]   held_uid   [LOCK_SLOTS];
  logic [UID_W-1:0]   superuser;

  logic [STATUS_W-1:0] status_due [$];
  logic [STATUS_W-1:0] want;

  function automatic void free_slot(int i);
    held_inode[i] = '0;
    held_fs[i]    = '0;
    held_desc[i]  = '0;
    held_uid[i]   = '0;
  endfunction

  function automatic logic [STATUS_W-1:0] predict_lock_status(
    input logic [OP_W-1:0]    op,
    input logic [INODE_W-1:0] ino,
    input logic [FS_W-1:0]    fs,
    input logic [DESC_W-1:0]  desc,
    input logic [UID_W-1:0]   caller,
    input logic [UID_W-1:0]   owner,
    input logic               others
  );
    logic [STATUS_W-1:0] st;
    int                  hit;
    bit                  done;
    st   = ST_OK;
    hit  = -1;
    done = 1'b0;
    // inode zero never matches, it marks a free slot
    if (ino != '0) begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        if (hit < 0 && held_inode[i] == ino && held_fs[i] == fs) hit = i;
      end
    end
    case (op)
      OP_CHECK: begin
        if (hit >= 0 && held_uid[hit] != caller) st = ST_ACCESS;
      end
      OP_RELEASE: begin
        if (ino != '0) begin
          for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (!done && held_inode[i] == ino && held_fs[i] == fs && held_desc[i] == desc) begin
              free_slot(i);
              done = 1'b1;
            end
          end
        end
      end
      OP_LOCK, OP_LOCK_NOOTHER: begin
        if (op == OP_LOCK_NOOTHER && others) begin
          st = ST_AGAIN;
        end else if (ino == '0) begin
          st = ST_INVALID;
        end else if (hit >= 0) begin
          st = ST_ALREADY;
        end else begin
          st = ST_NOSLOT;
          for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (!done && held_inode[i] == '0) begin
              held_inode[i] = ino;
              held_fs[i]    = fs;
              held_desc[i]  = desc;
              held_uid[i]   = caller;
              st            = ST_OK;
              done          = 1'b1;
            end
          end
        end
      end
      OP_UNLOCK, OP_FORCE_UNLOCK: begin
        if (hit < 0) begin
          st = ST_INVALID;
        end else if (held_uid[hit] == caller ||
                     (op == OP_FORCE_UNLOCK && (superuser == caller || owner == caller))) begin
          free_slot(hit);
          st = ST_OK;
        end else begin
          st = ST_NOPERM;
        end
      end
      default: st = ST_INVALID;
    endcase
    return st;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOCK_SLOTS; i++) free_slot(i);
      superuser = '0;
      status_due.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // results leave before the new request is queued, the block is never that fast
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected status, expected none, actual %0d",
                   $time, out_tdata[STATUS_W-1:0]);
        end else begin
          want = status_due.pop_front();
          if (out_tdata[STATUS_W-1:0] !== want) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata[STATUS_W-1:0]);
          end
        end
      end
      if (cfg_wr_en) superuser = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        status_due.push_back(predict_lock_status(in_tuser,
                                                 in_tdata[INODE_W-1:0],
                                                 in_tdata[FS_LSB +: FS_W],
                                                 in_tdata[DESC_LSB +: DESC_W],
                                                 in_tdata[CALLER_LSB +: UID_W],
                                                 in_tdata[OWNER_LSB +: UID_W],
                                                 in_tdata[OTHERS_BIT]));
      end
    end
  end

endmodule

### tb/tb_exclusive_file_lock_table.sv
// stimulus and verdict for the exclusive file lock table
module tb_exclusive_file_lock_table;
  import eflt_pkg::*;

  localparam int LOCK_SLOTS       = 8;
  localparam int RANDOM_PER_PHASE = 190;
  localparam int HOLD_CYCLES      = 400;
  localparam int CYCLE_LIMIT      = 700000;

  localparam logic [DESC_W-1:0] DESC_BY_PATH = '1;
  localparam logic [OP_W-1:0]   OP_UNDEF_LO  = 3'd6;
  localparam logic [OP_W-1:0]   OP_UNDEF_HI  = 3'd7;
  localparam logic [UID_W-1:0]  ROOT_UID     = 16'h1234;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [UID_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [OP_W-1:0]       in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int results_seen;
  int requests_sent = 0;
  int cycle_count;
  int tx_burst = 0;
  int rx_burst = 0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  logic [UID_W-1:0] su_now = '0;

  logic [INODE_W-1:0] inode_pool [12] = '{32'd1, 32'd2, 32'd3, 32'd100, 32'd101, 32'd102,
                                          32'd103, 32'd104, 32'd105, 32'd106,
                                          32'h8000_0000, 32'hFFFF_FFFF};
  logic [FS_W-1:0]    fs_pool    [3]  = '{32'h0, 32'h1, 32'hFFFF_FFFF};
  logic [DESC_W-1:0]  desc_pool  [4]  = '{9'h1FF, 9'd0, 9'd1, 9'd255};

  exclusive_file_lock_table #(.LOCK_SLOTS(LOCK_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lock_table_checker #(.LOCK_SLOTS(LOCK_SLOTS)) u_status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .results_seen(results_seen)
  );

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int idle_len(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(40, 100);
  endfunction

  function automatic logic [UID_W-1:0] pick_uid();
    case ($urandom_range(0, 9))
      0, 1:    return 16'h0000;
      2:       return 16'h0001;
      3:       return 16'h0002;
      4, 5:    return 16'hFFFF;
      6, 7:    return su_now;
      default: return UID_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0]    op,
                              input logic [INODE_W-1:0] ino,
                              input logic [FS_W-1:0]    fs,
                              input logic [DESC_W-1:0]  desc,
                              input logic [UID_W-1:0]   caller,
                              input logic [UID_W-1:0]   owner,
                              input logic               others);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({others, owner, caller, desc, fs, ino});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    gap = idle_len(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_request();
    logic [OP_W-1:0]    op;
    logic [INODE_W-1:0] ino;
    logic [FS_W-1:0]    fs;
    logic [DESC_W-1:0]  desc;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 14)      op = OP_CHECK;
    else if (r < 26) op = OP_RELEASE;
    else if (r < 48) op = OP_LOCK;
    else if (r < 58) op = OP_LOCK_NOOTHER;
    else if (r < 76) op = OP_UNLOCK;
    else if (r < 96) op = OP_FORCE_UNLOCK;
    else             op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
    r = $urandom_range(0, 99);
    if (r < 90)      ino = inode_pool[$urandom_range(0, 11)];
    else if (r < 92) ino = '0;
    else             ino = $urandom;
    fs   = ($urandom_range(0, 9) != 0) ? fs_pool[$urandom_range(0, 2)] : $urandom;
    desc = ($urandom_range(0, 4) != 0) ? desc_pool[$urandom_range(0, 3)]
                                       : DESC_W'($urandom_range(0, 255));
    send_request(op, ino, fs, desc, pick_uid(), pick_uid(), 1'($urandom_range(0, 1)));
  endtask

  // the block is idle once every request has its status and the sweep is over
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
    repeat (LOCK_SLOTS + 3) @(posedge clk);
  endtask

  task automatic write_superuser(input logic [UID_W-1:0] uid);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= uid;
    su_now = uid;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [UID_W-1:0] uid, input bit with_hold);
    wait_drained();
    write_superuser(uid);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (with_hold && i == 20) hold_off_req = 1'b1;
      send_random_request();
    end
  endtask

  // receiver: random ready, plus one long hold-off while requests keep coming
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        gap = idle_len(rx_burst);
        if (gap == 0) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_exclusive_file_lock_table: done, errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_superuser(ROOT_UID);

    // empty table, then lock a key of all ones by path
    send_request(OP_CHECK, 32'd1, 32'h0, 9'd0, 16'd5, 16'd5, 1'b0);
    send_request(OP_LOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DESC_BY_PATH, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(OP_LOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd4, 16'h0000, 16'h0000, 1'b0);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd4, 16'h0000, 16'hFFFF, 1'b0);
    // lock with no other users, refused and then granted
    send_request(OP_LOCK_NOOTHER, 32'd2, 32'h0, 9'd0, 16'd0, 16'd0, 1'b1);
    send_request(OP_LOCK_NOOTHER, 32'd1, 32'h0, 9'd0, 16'd0, 16'd0, 1'b0);
    // inode zero on lock, check, release and unlock requests
    send_request(OP_LOCK, 32'd0, 32'h0, 9'd0, 16'd0, 16'd0, 1'b0);
    send_request(OP_CHECK, 32'd0, 32'h0, 9'd0, 16'd1, 16'd1, 1'b0);
    send_request(OP_RELEASE, 32'd0, 32'h0, 9'd0, 16'd0, 16'd0, 1'b0);
    send_request(OP_UNLOCK, 32'd0, 32'h0, 9'd0, 16'd0, 16'd0, 1'b0);
    // unlock rights: stranger, file owner by force, superuser by force
    send_request(OP_UNLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DESC_BY_PATH, 16'd0, 16'd0, 1'b0);
    send_request(OP_FORCE_UNLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0, 16'd7, 16'd7, 1'b0);
    send_request(OP_FORCE_UNLOCK, 32'd1, 32'h0, 9'd0, 16'd9, 16'd3, 1'b0);
    send_request(OP_FORCE_UNLOCK, 32'd1, 32'h0, 9'd0, ROOT_UID, 16'd3, 1'b1);
    send_request(OP_LOCK, 32'd5, 32'h1, 9'd255, 16'd3, 16'd3, 1'b0);
    send_request(OP_RELEASE, 32'd5, 32'h1, 9'd0, 16'd3, 16'd3, 1'b0);
    send_request(OP_CHECK, 32'd5, 32'h1, 9'd255, 16'd4, 16'd3, 1'b1);
    // fill the remaining slots, the last lock finds none free
    for (int k = 0; k < LOCK_SLOTS; k++)
      send_request(OP_LOCK, 32'd100 + k, 32'h0, DESC_W'(k), UID_W'(k % 3), 16'hFFFF, 1'b0);
    send_request(OP_RELEASE, 32'd5, 32'h1, 9'd255, 16'd3, 16'd3, 1'b0);
    send_request(OP_UNDEF_LO, 32'd1, 32'h0, 9'd0, 16'd0, 16'd0, 1'b0);
    send_request(OP_UNDEF_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DESC_BY_PATH, 16'hFFFF, 16'hFFFF, 1'b1);

    run_random_phase(16'h0000, 1'b0);
    run_random_phase(16'hFFFF, 1'b1);
    run_random_phase(16'h0002, 1'b0);
    run_random_phase(UID_W'($urandom_range(3, 16'hFFFE)), 1'b0);
    wait_drained();

    if (fail_count == 0 && results_seen == requests_sent) begin
      $display("tb_exclusive_file_lock_table: done, clean");
    end else begin
      $display("tb_exclusive_file_lock_table: done, errors");
    end
    $finish;
  end

endmodule
